[hw/rtl/out_of_order_ack_tracker_defines.svh]
// ----------------------------------------------------------------------------
// out_of_order_ack_tracker_defines
// Assertion macros shared by the ack tracker RTL.
// ----------------------------------------------------------------------------
`ifndef OUT_OF_ORDER_ACK_TRACKER_DEFINES_SVH
`define OUT_OF_ORDER_ACK_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define OOAT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("ooat assertion failed");
// property checked at every edge, reset included
`define OOAT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("ooat assertion failed");
`else
`define OOAT_ASSERT(lbl, clk, rstn, prop)
`define OOAT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/ooat_pkg.sv]
// ----------------------------------------------------------------------------
// ooat_pkg
// Widths, codes and reset values of the out-of-order ack tracker.
// ----------------------------------------------------------------------------
package ooat_pkg;

	localparam int unsigned SEQ_W      = 64;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned DEF_WINDOW = 64;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_ACK   = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_ACCEPT = 2'd0;
	localparam logic [1:0] STATUS_NOOP   = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_NEXT_SEQ = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PREFIX   = 8'd1;

	// register reset values
	localparam logic [SEQ_W-1:0] RST_NEXT_SEQ = 64'd1;
	localparam logic [SEQ_W-1:0] RST_PREFIX   = 64'd0;

endpackage

[hw/rtl/out_of_order_ack_tracker.sv]
// Steps: allocate runs EXEC, DONE, then the output register; an ack runs EXEC, CHECK, and if
// accepted SCAN with k prefix steps (k 0 to WINDOW), then DONE and the output register.
// Throughput: one item at a time; the shared 64-bit adder does the subtract,
// the counter increment and each one-bit prefix step, one use per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): next counter 1, prefix 0, bitmap clear, no clearing pass.
// ----------------------------------------------------------------------------
// out_of_order_ack_tracker
// Sequence allocator and sliding-window scoreboard for out-of-order acks.
// ----------------------------------------------------------------------------
`include "out_of_order_ack_tracker_defines.svh"

module out_of_order_ack_tracker import ooat_pkg::*; #(
	parameter int unsigned WINDOW = DEF_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [SEQ_W-1:0]     ack_seq,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [SEQ_W-1:0]     given_seq,
	output logic [SEQ_W-1:0]     prefix_now,
	output logic                 advanced,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEQ_W-1:0]     cfg_data
);

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CHECK,
		S_SCAN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                cmd_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [SEQ_W-1:0]    next_q;
	logic [SEQ_W-1:0]    prefix_q;
	logic [WINDOW-1:0]   bitmap_q;
	logic [SEQ_W:0]      diff_q;
	logic [1:0]          stat_q;
	logic [SEQ_W-1:0]    given_q;
	logic                adv_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [SEQ_W-1:0]    given_seq_q;
	logic [SEQ_W-1:0]    prefix_now_q;
	logic                advanced_q;

	logic [SEQ_W-1:0]    add_a;
	logic [SEQ_W-1:0]    add_b;
	logic [SEQ_W:0]      add_sum;
	logic                at_or_below;
	logic                beyond;
	logic [IDX_W-1:0]    bit_idx;
	logic                in_xfer;
	logic                cfg_xfer;
	logic                out_free;

	// handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign given_seq  = given_seq_q;
	assign prefix_now = prefix_now_q;
	assign advanced   = advanced_q;

	// shared adder: a + b + 1, operands picked by the sequencer
	always_comb begin
		add_a = prefix_q;
		add_b = '0;
		unique case (state_q)
			S_EXEC: begin
				if (cmd_q == CMD_ALLOC) begin
					add_a = next_q;
				end else begin
					add_a = seq_q;
					add_b = ~prefix_q;
				end
			end
			default: begin
				add_a = prefix_q;
				add_b = '0;
			end
		endcase
		add_sum = {1'b0, add_a} + {1'b0, add_b} + {{SEQ_W{1'b0}}, 1'b1};
	end

	// classify the registered difference seq - prefix (carry set means no borrow)
	assign at_or_below = !diff_q[SEQ_W] || (diff_q[SEQ_W-1:0] == '0);
	assign beyond      = diff_q[SEQ_W-1:0] > SEQ_W'(WINDOW);
	assign bit_idx     = diff_q[IDX_W-1:0] - IDX_W'(1);

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_q      <= RST_NEXT_SEQ;
			prefix_q    <= RST_PREFIX;
			bitmap_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken downstream, unless a new one is loaded on this edge
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cfg_xfer) begin
						if (cfg_index == CFG_START_NEXT_SEQ) begin
							next_q <= cfg_data;
						end else if (cfg_index == CFG_START_PREFIX) begin
							prefix_q <= cfg_data;
							bitmap_q <= '0;
						end
					end
					if (in_xfer) begin
						cmd_q   <= cmd;
						seq_q   <= ack_seq;
						stat_q  <= STATUS_ACCEPT;
						given_q <= '0;
						adv_q   <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_ALLOC) begin
						given_q <= next_q;
						next_q  <= add_sum[SEQ_W-1:0];
						state_q <= S_DONE;
					end else begin
						diff_q  <= add_sum;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (at_or_below) begin
						stat_q  <= STATUS_NOOP;
						state_q <= S_DONE;
					end else if (beyond) begin
						stat_q  <= STATUS_REJECT;
						state_q <= S_DONE;
					end else begin
						bitmap_q <= bitmap_q | (WINDOW'(1) << bit_idx);
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one prefix step per cycle over the run of marked bits
					if (bitmap_q[0]) begin
						bitmap_q <= bitmap_q >> 1;
						prefix_q <= add_sum[SEQ_W-1:0];
						adv_q    <= 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						status_q     <= stat_q;
						given_seq_q  <= given_q;
						prefix_now_q <= prefix_q;
						advanced_q   <= adv_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`OOAT_ASSERT(a_busy_after_xfer, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	`OOAT_ASSERT(a_idle_run_closed, clk, arst_n, (state_q == S_IDLE) |-> !bitmap_q[0])
	`OOAT_ASSERT(a_done_holds, clk, arst_n,
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
	`OOAT_ASSERT(a_adv_accepted, clk, arst_n,
		(out_valid && advanced) |-> (status == STATUS_ACCEPT))
	`OOAT_ASSERT(a_scan_step, clk, arst_n,
		(state_q == S_SCAN && bitmap_q[0]) |=> (prefix_q == $past(prefix_q) + 64'd1))

endmodule
